@@ src/phsc_pkg.sv @@
// Shared constants and types for the per-host sequence checker.
// No dependencies; imported by the top level.
`default_nettype none

package phsc_pkg;

	localparam int unsigned HOST_ENTRIES_DEF = 16;
	localparam int unsigned SEQ_BITS_DEF     = 16;

	localparam int unsigned HOST_W  = 32;
	localparam int unsigned SEQIN_W = 16;
	localparam int unsigned COUNT_W = 32;
	localparam int unsigned IN_DATA_W  = 48;
	localparam int unsigned OUT_DATA_W = 40;

	typedef logic [2:0] verdict_t;

	localparam verdict_t VERDICT_IGNORED  = 3'd0;
	localparam verdict_t VERDICT_KNOWN    = 3'd1;
	localparam verdict_t VERDICT_NEW      = 3'd2;
	localparam verdict_t VERDICT_MISORDER = 3'd3;
	localparam verdict_t VERDICT_FULL     = 3'd4;

endpackage

`default_nettype wire

@@ src/per_host_sequence_checker.sv @@
// Top level of the per-host sequence checker: sequencer, valid bits and counter.
// Depends on phsc_pkg and phsc_ram (host and last-sequence table).
//
// Each transaction on the input stream is one packet descriptor; each produces
// exactly one result transaction. A non-video descriptor passes through ST_DONE
// and is loaded into the output register once that register is free. A video
// descriptor scans the host table one entry per cycle through the single read
// port of the table RAM, stopping early when the host matches an entry, then
// passes through ST_DECIDE and ST_DONE before its result is loaded. The input is
// not ready while a descriptor is being processed and becomes ready again the
// cycle after the result is loaded. A finished result waits in the output
// register and the next descriptor may be accepted meanwhile.
`default_nettype none

module per_host_sequence_checker
	import phsc_pkg::*;
#(
	parameter int unsigned HOST_ENTRIES = HOST_ENTRIES_DEF,
	parameter int unsigned SEQ_BITS     = SEQ_BITS_DEF
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire [IN_DATA_W-1:0]    s_axis_tdata,  // host_address[31:0], sequence_number[47:32]
	input  wire                    s_axis_tuser,  // is_video
	output logic                   m_axis_tvalid,
	input  wire                    m_axis_tready,
	output logic [OUT_DATA_W-1:0]  m_axis_tdata   // verdict[2:0], out_of_sequence_total[34:3]
);

	localparam int unsigned IDX_W = (HOST_ENTRIES > 1) ? $clog2(HOST_ENTRIES) : 1;
	localparam int unsigned ROW_W = HOST_W + SEQ_BITS;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HOST_ENTRIES - 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_DECIDE = 2'd2;
	localparam logic [1:0] ST_DONE   = 2'd3;

	logic [1:0]              state_q;
	logic [HOST_W-1:0]       addr_q;
	logic [SEQ_BITS-1:0]     seq_q;
	logic [IDX_W-1:0]        scan_idx_q;
	logic                    issuing_q;
	logic                    rd_pend_q;
	logic [IDX_W-1:0]        rd_idx_q;
	logic                    free_found_q;
	logic [IDX_W-1:0]        free_idx_q;
	logic                    hit_q;
	logic [IDX_W-1:0]        hit_idx_q;
	logic [SEQ_BITS-1:0]     hit_seq_q;
	logic [HOST_ENTRIES-1:0] valid_q;
	logic [COUNT_W-1:0]      misorder_q;
	verdict_t                verdict_q;
	logic                    out_valid_q;
	logic [OUT_DATA_W-1:0]   out_data_q;

	logic [31:0]             seq_wide;
	logic [ROW_W-1:0]        rd_row;
	logic [HOST_W-1:0]       rd_host;
	logic [SEQ_BITS-1:0]     rd_seq;
	logic                    rd_valid;
	logic                    hit_now;
	logic                    ram_we;
	logic [IDX_W-1:0]        ram_waddr;
	logic [ROW_W-1:0]        ram_wdata;
	logic                    seq_newer;
	logic                    accept;

	assign seq_wide  = 32'(s_axis_tdata[47:32]);
	assign rd_host   = rd_row[HOST_W-1:0];
	assign rd_seq    = rd_row[ROW_W-1:HOST_W];
	assign rd_valid  = valid_q[rd_idx_q];
	assign hit_now   = rd_pend_q && rd_valid && (rd_host == addr_q);
	assign seq_newer = seq_q > hit_seq_q;
	assign accept    = s_axis_tvalid && s_axis_tready;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = free_idx_q;
		ram_wdata = {seq_q, addr_q};
		if (state_q == ST_DECIDE) begin
			if (hit_q) begin
				ram_we    = seq_newer;
				ram_waddr = hit_idx_q;
			end else begin
				ram_we    = free_found_q;
				ram_waddr = free_idx_q;
			end
		end
	end

	phsc_ram #(
		.WIDTH(ROW_W),
		.DEPTH(HOST_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (scan_idx_q),
		.rdata (rd_row)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= s_axis_tdata[HOST_W-1:0];
			seq_q  <= seq_wide[SEQ_BITS-1:0];
		end
		rd_idx_q <= scan_idx_q;
		if (state_q == ST_SCAN && hit_now) begin
			hit_idx_q <= rd_idx_q;
			hit_seq_q <= rd_seq;
		end
		if (state_q == ST_SCAN && rd_pend_q && !rd_valid && !free_found_q) begin
			free_idx_q <= rd_idx_q;
		end
		if (state_q == ST_DONE && (!out_valid_q || m_axis_tready)) begin
			out_data_q <= {{(OUT_DATA_W - COUNT_W - 3){1'b0}}, misorder_q, verdict_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			scan_idx_q   <= '0;
			issuing_q    <= 1'b0;
			rd_pend_q    <= 1'b0;
			free_found_q <= 1'b0;
			hit_q        <= 1'b0;
			valid_q      <= '0;
			misorder_q   <= '0;
			verdict_q    <= VERDICT_IGNORED;
			out_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!out_valid_q || m_axis_tready)) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						scan_idx_q   <= '0;
						rd_pend_q    <= 1'b0;
						free_found_q <= 1'b0;
						hit_q        <= 1'b0;
						if (s_axis_tuser) begin
							issuing_q <= 1'b1;
							state_q   <= ST_SCAN;
						end else begin
							verdict_q <= VERDICT_IGNORED;
							state_q   <= ST_DONE;
						end
					end
				end
				ST_SCAN: begin
					rd_pend_q <= issuing_q;
					if (rd_pend_q && !rd_valid && !free_found_q) begin
						free_found_q <= 1'b1;
					end
					if (hit_now || (rd_pend_q && rd_idx_q == LAST_IDX)) begin
						if (hit_now) begin
							hit_q <= 1'b1;
						end
						issuing_q <= 1'b0;
						state_q   <= ST_DECIDE;
					end else if (issuing_q) begin
						if (scan_idx_q == LAST_IDX) begin
							issuing_q <= 1'b0;
						end else begin
							scan_idx_q <= scan_idx_q + 1'b1;
						end
					end
				end
				ST_DECIDE: begin
					rd_pend_q <= 1'b0;
					if (hit_q) begin
						if (seq_newer) begin
							verdict_q <= VERDICT_KNOWN;
						end else begin
							verdict_q <= VERDICT_MISORDER;
							if (misorder_q != '1) begin
								misorder_q <= misorder_q + 1'b1;
							end
						end
					end else if (free_found_q) begin
						valid_q[free_idx_q] <= 1'b1;
						verdict_q           <= VERDICT_NEW;
					end else begin
						verdict_q <= VERDICT_FULL;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("input still ready after a transaction was accepted");

	a_count_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> misorder_q >= $past(misorder_q))
		else $error("out-of-sequence count decreased");

	a_hit_entry_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE && hit_q) |-> valid_q[hit_idx_q])
		else $error("matched entry is not valid");

	a_claim_free_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE && !hit_q && free_found_q) |-> !valid_q[free_idx_q])
		else $error("claimed entry is already valid");

	a_verdict_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q[2:0] <= VERDICT_FULL))
		else $error("result carries an undefined verdict");
`endif

endmodule

`default_nettype wire

@@ src/phsc_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module phsc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire                   clk,
	input  wire                   we,
	input  wire [ADDR_W-1:0]      waddr,
	input  wire [WIDTH-1:0]       wdata,
	input  wire [ADDR_W-1:0]      raddr,
	output logic [WIDTH-1:0]      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire
